// ===== rtl/bmes_pkg.sv =====
// Shared types, constants and helper functions of the bicycle model Euler step block.
// Used by every module in this folder; depends on nothing.
`default_nettype none
package bmes_pkg;

    // Euler step is 2^-DT_SHIFT seconds.
    localparam int DT_SHIFT = 4;

    localparam logic signed [31:0] ONE_Q         = 32'sd65536;
    localparam logic signed [31:0] PI_Q          = 32'sd205887;
    localparam logic signed [31:0] TWO_PI_Q      = 32'sd411775;
    localparam logic signed [31:0] HALF_PI_Q     = 32'sd102944;
    localparam logic signed [31:0] CORDIC_GAIN_Q = 32'sd39797;
    localparam logic signed [31:0] MAX32         = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32         = 32'sh80000000;
    localparam logic signed [33:0] MAX34         = 34'sd2147483647;
    localparam logic signed [33:0] MIN34         = -34'sd2147483648;

    // Configuration register indexes.
    localparam logic [2:0] REG_INV_WHEELBASE   = 3'd0;
    localparam logic [2:0] REG_INV_CHAR_SPD_SQ = 3'd1;
    localparam logic [2:0] REG_STEER_LAG_GAIN  = 3'd2;
    localparam logic [2:0] REG_ACCEL_LAG_GAIN  = 3'd3;
    localparam logic [2:0] REG_STEER_RATE_LIM  = 3'd4;
    localparam logic [2:0] REG_STEER_ANGLE_LIM = 3'd5;
    localparam logic [2:0] REG_ACCEL_LOWER_LIM = 3'd6;
    localparam logic [2:0] REG_ACCEL_UPPER_LIM = 3'd7;

    // State word indexes for load mode.
    localparam logic [2:0] LD_POS_X   = 3'd0;
    localparam logic [2:0] LD_POS_Y   = 3'd1;
    localparam logic [2:0] LD_HEADING = 3'd2;
    localparam logic [2:0] LD_STEER   = 3'd3;
    localparam logic [2:0] LD_SPEED   = 3'd4;
    localparam logic [2:0] LD_ACCEL   = 3'd5;
    localparam logic [2:0] LD_TIME    = 3'd6;
    localparam logic [2:0] LD_NONE    = 3'd7;

    // Request to the angle unit: start a pass, with or without CORDIC rotation.
    typedef struct packed {
        logic start;
        logic rotate;
    } ang_req_t;

    // Saturate a 34-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > MAX34) begin
            r = MAX32;
        end else if (v < MIN34) begin
            r = MIN32;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // CORDIC arctangent table, Q16.16 radians.
    function automatic logic signed [31:0] atan_q(input logic [3:0] i);
        logic signed [31:0] r;
        unique case (i)
            4'd0:  r = 32'sd51472;
            4'd1:  r = 32'sd30386;
            4'd2:  r = 32'sd16055;
            4'd3:  r = 32'sd8150;
            4'd4:  r = 32'sd4091;
            4'd5:  r = 32'sd2047;
            4'd6:  r = 32'sd1024;
            4'd7:  r = 32'sd512;
            4'd8:  r = 32'sd256;
            4'd9:  r = 32'sd128;
            4'd10: r = 32'sd64;
            4'd11: r = 32'sd32;
            4'd12: r = 32'sd16;
            4'd13: r = 32'sd8;
            4'd14: r = 32'sd4;
            4'd15: r = 32'sd2;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bmes_mul.sv =====
// Shared Q16.16 multiplier: registered 64-bit product, floor shift by 16, saturation.
// Depends on bmes_pkg.
`default_nettype none
module bmes_mul (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic signed [31:0]      res
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] shifted;

    // Product register; the result is read the cycle after the operands.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    // Arithmetic shift rounds toward minus infinity, then saturate.
    always_comb begin
        shifted = prod_reg >>> 16;
        if (shifted > 64'(bmes_pkg::MAX32)) begin
            res = bmes_pkg::MAX32;
        end else if (shifted < 64'(bmes_pkg::MIN32)) begin
            res = bmes_pkg::MIN32;
        end else begin
            res = shifted[31:0];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bmes_div.sv =====
// Iterative Q16.16 divider: num*2^16/den truncated toward zero, one quotient bit a cycle.
// Depends on bmes_pkg.
`default_nettype none
module bmes_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic signed [31:0]      quot,
    output logic                    done
);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIN  = 3'b100
    } div_state_t;

    div_state_t         state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [47:0]        n_reg, n_next;
    logic [31:0]        d_reg, d_next;
    logic [31:0]        rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] quot_reg, quot_next;
    logic               done_reg, done_next;
    logic [32:0]        shifted;
    logic               ge;
    logic [31:0]        num_mag;

    assign quot = quot_reg;
    assign done = done_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        quot_next  = quot_reg;
        done_next  = 1'b0;
        shifted    = {rem_reg, n_reg[47]};
        ge         = shifted >= {1'b0, d_reg};
        num_mag    = num[31] ? 32'(-num) : 32'(num);
        unique case (state_reg)
            D_IDLE: begin
                if (start) begin
                    // A zero divisor gives the signed limit of the numerator.
                    if (den == 32'sd0) begin
                        if (num > 32'sd0) begin
                            quot_next = bmes_pkg::MAX32;
                        end else if (num < 32'sd0) begin
                            quot_next = bmes_pkg::MIN32;
                        end else begin
                            quot_next = 32'sd0;
                        end
                        done_next = 1'b1;
                    end else begin
                        n_next     = {num_mag, 16'd0};
                        d_next     = den[31] ? 32'(-den) : 32'(den);
                        rem_next   = 32'd0;
                        neg_next   = num[31] ^ den[31];
                        cnt_next   = 6'd0;
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN: begin
                // Restoring step; quotient bits shift in behind the dividend.
                rem_next = ge ? 32'(shifted - {1'b0, d_reg}) : shifted[31:0];
                n_next   = {n_reg[46:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd47) begin
                    state_next = D_FIN;
                end
            end
            D_FIN: begin
                // Apply the sign and saturate.
                if (neg_reg) begin
                    if (n_reg > 48'h0000_8000_0000) begin
                        quot_next = bmes_pkg::MIN32;
                    end else begin
                        quot_next = 32'(32'd0 - n_reg[31:0]);
                    end
                end else begin
                    if (n_reg > 48'h0000_7fff_ffff) begin
                        quot_next = bmes_pkg::MAX32;
                    end else begin
                        quot_next = n_reg[31:0];
                    end
                end
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg  <= cnt_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

endmodule
`default_nettype wire

// ===== rtl/bmes_angle.sv =====
// Angle unit: reduces an angle into [-pi, pi) by repeated compare and subtract, then
// optionally runs 16 CORDIC rotations for cos and sin. Depends on bmes_pkg.
`default_nettype none
module bmes_angle (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bmes_pkg::ang_req_t req,
    input  wire logic signed [33:0] angle,
    output logic signed [31:0]      wrapped,
    output logic signed [31:0]      cos_out,
    output logic signed [31:0]      sin_out,
    output logic                    done
);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_RED  = 4'b0010,
        A_FOLD = 4'b0100,
        A_ROT  = 4'b1000
    } ang_state_t;

    ang_state_t         state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [35:0]        rem_reg, rem_next;
    logic               rot_reg, rot_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic signed [31:0] wrap_reg, wrap_next;
    logic               done_reg, done_next;
    logic signed [35:0] biased;
    logic [35:0]        sub;
    logic signed [31:0] w;
    logic signed [31:0] xs;
    logic signed [31:0] ys;

    assign wrapped = wrap_reg;
    assign cos_out = neg_reg ? -x_reg : x_reg;
    assign sin_out = neg_reg ? -y_reg : y_reg;
    assign done    = done_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        rot_next   = rot_reg;
        neg_next   = neg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        wrap_next  = wrap_reg;
        done_next  = 1'b0;
        biased     = 36'(angle) + 36'(bmes_pkg::PI_Q);
        sub        = 36'(bmes_pkg::TWO_PI_Q) << cnt_reg;
        w          = signed'(rem_reg[31:0]) - bmes_pkg::PI_Q;
        xs         = x_reg >>> cnt_reg;
        ys         = y_reg >>> cnt_reg;
        unique case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    // Shift negative inputs up by a large multiple of the period.
                    if (biased[35]) begin
                        rem_next = 36'(biased + (36'(bmes_pkg::TWO_PI_Q) <<< 15));
                    end else begin
                        rem_next = 36'(biased);
                    end
                    rot_next   = req.rotate;
                    cnt_next   = 4'd15;
                    state_next = A_RED;
                end
            end
            A_RED: begin
                // Subtract period * 2^k where it fits, k counting down.
                if (rem_reg >= sub) begin
                    rem_next = rem_reg - sub;
                end
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) begin
                    state_next = A_FOLD;
                end
            end
            A_FOLD: begin
                wrap_next = w;
                if (!rot_reg) begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end else begin
                    // Fold into [-pi/2, pi/2]; a fold negates both results.
                    if (w > bmes_pkg::HALF_PI_Q) begin
                        z_next   = w - bmes_pkg::PI_Q;
                        neg_next = 1'b1;
                    end else if (w < -bmes_pkg::HALF_PI_Q) begin
                        z_next   = w + bmes_pkg::PI_Q;
                        neg_next = 1'b1;
                    end else begin
                        z_next   = w;
                        neg_next = 1'b0;
                    end
                    x_next     = bmes_pkg::CORDIC_GAIN_Q;
                    y_next     = 32'sd0;
                    cnt_next   = 4'd0;
                    state_next = A_ROT;
                end
            end
            A_ROT: begin
                // One rotation-mode CORDIC iteration per cycle.
                if (z_reg >= 32'sd0) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - bmes_pkg::atan_q(cnt_reg);
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + bmes_pkg::atan_q(cnt_reg);
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        rot_reg  <= rot_next;
        neg_reg  <= neg_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        wrap_reg <= wrap_next;
    end

endmodule
`default_nettype wire

// ===== rtl/bicycle_model_euler_step_top.sv =====
// Top level of the kinematic bicycle model Euler step: state, configuration and sequencer.
// Depends on bmes_pkg, bmes_mul, bmes_div and bmes_angle.
//
// Usage: each input beat on the s_ channel either loads one state word (s_mode high)
// or advances the vehicle state by one Euler step with the given steering and
// acceleration commands. Every input beat yields one result beat on the m_ channel
// carrying all seven state words after the item.
// A step runs the angle unit twice (16 reduction steps, a fold and 16 CORDIC rotations
// each), the divider twice (48 iterations each), the multiplier for nine products and
// the angle unit once more for a reduction pass that wraps the heading. A load skips
// the shared units and goes straight to the output register. The sequencer handles one
// item at a time; s_ready is high only while it is idle.
// The result sits in an output register: a stalled receiver holds the result and
// blocks the next item only once that item is finished. Configuration writes go
// through cfg_wr_en, cfg_addr and cfg_wr_data and must only be issued while the
// block is idle.
// Synchronous active-low reset restores the default registers, zeroes the state
// and empties the output register.
`default_nettype none
module bicycle_model_euler_step_top #(
    parameter int DT_SHIFT = bmes_pkg::DT_SHIFT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wr_data,
    // Input channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_mode,
    input  wire logic signed [31:0] s_steer_command,
    input  wire logic signed [31:0] s_accel_command,
    input  wire logic [2:0]         s_load_index,
    input  wire logic signed [31:0] s_load_value,
    // Result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_out_pos_x,
    output logic signed [31:0]      m_out_pos_y,
    output logic signed [31:0]      m_out_heading,
    output logic signed [31:0]      m_out_steer_angle,
    output logic signed [31:0]      m_out_speed,
    output logic signed [31:0]      m_out_accel,
    output logic signed [31:0]      m_out_time
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_ANG_H  = 10'b0000000010,
        ST_ANG_S  = 10'b0000000100,
        ST_DIV_T  = 10'b0000001000,
        ST_MUL    = 10'b0000010000,
        ST_DIV_G  = 10'b0000100000,
        ST_MUL_H  = 10'b0001000000,
        ST_HSUM   = 10'b0010000000,
        ST_WRAP_H = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } seq_state_t;

    // Multiplier program steps.
    localparam logic [3:0] MS_V2     = 4'd0;
    localparam logic [3:0] MS_V2K    = 4'd1;
    localparam logic [3:0] MS_DX     = 4'd2;
    localparam logic [3:0] MS_DY     = 4'd3;
    localparam logic [3:0] MS_VW     = 4'd4;
    localparam logic [3:0] MS_VWT    = 4'd5;
    localparam logic [3:0] MS_DSTEER = 4'd6;
    localparam logic [3:0] MS_DACCEL = 4'd7;
    localparam logic [3:0] MS_LAST   = 4'd8;

    seq_state_t state_reg, state_next;
    logic [3:0] mcnt_reg, mcnt_next;

    // Configuration registers.
    logic [30:0]        inv_wb_reg, inv_cs_reg, slg_reg, alg_reg;
    logic [30:0]        srl_reg, sal_reg, aul_reg;
    logic signed [31:0] all_reg;

    // Vehicle state.
    logic signed [31:0] pos_x_reg, pos_y_reg, heading_reg, steer_reg;
    logic signed [31:0] speed_reg, accel_reg, time_reg;

    // Per-step working registers.
    logic signed [31:0] dc_reg, ac_reg, ch_reg, sh_reg, tn_reg, den_reg, gss_reg;
    logic signed [31:0] dx_reg, dy_reg, t2_reg, ds_reg, da_reg;

    // Output register.
    logic               m_valid_reg;
    logic signed [31:0] o_x_reg, o_y_reg, o_h_reg, o_s_reg, o_v_reg, o_a_reg, o_t_reg;

    // Shared units.
    bmes_pkg::ang_req_t ang_req;
    logic signed [33:0] ang_in;
    logic signed [31:0] ang_wrapped, ang_cos, ang_sin;
    logic               ang_done;
    logic               div_start;
    logic signed [31:0] div_num, div_den, div_q;
    logic               div_done;
    logic               mul_en;
    logic signed [31:0] mul_a, mul_b, mul_res;

    logic               s_fire;
    logic               m_load;
    logic signed [31:0] steer_err, accel_err, srl_s, sal_s, aul_s, ds_clamped;
    logic signed [31:0] steer_new, accel_new;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    assign m_valid           = m_valid_reg;
    assign m_out_pos_x       = o_x_reg;
    assign m_out_pos_y       = o_y_reg;
    assign m_out_heading     = o_h_reg;
    assign m_out_steer_angle = o_s_reg;
    assign m_out_speed       = o_v_reg;
    assign m_out_accel       = o_a_reg;
    assign m_out_time        = o_t_reg;

    bmes_angle u_angle (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ang_req),
        .angle   (ang_in),
        .wrapped (ang_wrapped),
        .cos_out (ang_cos),
        .sin_out (ang_sin),
        .done    (ang_done)
    );

    bmes_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_q),
        .done    (div_done)
    );

    bmes_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .res  (mul_res)
    );

    // Differences and limits used by the multiplier program and the update.
    always_comb begin
        steer_err = bmes_pkg::sat32(34'(dc_reg) - 34'(steer_reg));
        accel_err = bmes_pkg::sat32(34'(ac_reg) - 34'(accel_reg));
        srl_s     = signed'({1'b0, srl_reg});
        sal_s     = signed'({1'b0, sal_reg});
        aul_s     = signed'({1'b0, aul_reg});
        if (mul_res > srl_s) begin
            ds_clamped = srl_s;
        end else if (mul_res < -srl_s) begin
            ds_clamped = -srl_s;
        end else begin
            ds_clamped = mul_res;
        end
        // Steering angle after integration, clamped symmetrically.
        steer_new = bmes_pkg::sat32(34'(steer_reg) + 34'(ds_reg >>> DT_SHIFT));
        if (steer_new > sal_s) begin
            steer_new = sal_s;
        end
        if (steer_new < -sal_s) begin
            steer_new = -sal_s;
        end
        // Acceleration after integration: upper limit first, lower limit wins.
        accel_new = bmes_pkg::sat32(34'(accel_reg) + 34'(da_reg >>> DT_SHIFT));
        if (accel_new > aul_s) begin
            accel_new = aul_s;
        end
        if (accel_new < all_reg) begin
            accel_new = all_reg;
        end
    end

    // Sequencer: drives the shared units and steps through the item.
    always_comb begin
        state_next = state_reg;
        mcnt_next  = mcnt_reg;
        ang_req    = '0;
        ang_in     = 34'(heading_reg);
        div_start  = 1'b0;
        div_num    = ang_sin;
        div_den    = ang_cos;
        mul_en     = 1'b0;
        mul_a      = 32'sd0;
        mul_b      = 32'sd0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_mode) begin
                        state_next = ST_OUT;
                    end else begin
                        ang_req.start  = 1'b1;
                        ang_req.rotate = 1'b1;
                        state_next     = ST_ANG_H;
                    end
                end
            end
            ST_ANG_H: begin
                if (ang_done) begin
                    ang_req.start  = 1'b1;
                    ang_req.rotate = 1'b1;
                    ang_in         = 34'(steer_reg);
                    state_next     = ST_ANG_S;
                end
            end
            ST_ANG_S: begin
                // tan of the steering angle as sin over cos.
                if (ang_done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_T;
                end
            end
            ST_DIV_T: begin
                if (div_done) begin
                    mcnt_next  = MS_V2;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                mul_en    = 1'b1;
                mcnt_next = mcnt_reg + 4'd1;
                unique case (mcnt_reg)
                    MS_V2: begin
                        mul_a = speed_reg;
                        mul_b = speed_reg;
                    end
                    MS_V2K: begin
                        mul_a = mul_res;
                        mul_b = signed'({1'b0, inv_cs_reg});
                    end
                    MS_DX: begin
                        mul_a = speed_reg;
                        mul_b = ch_reg;
                    end
                    MS_DY: begin
                        mul_a = speed_reg;
                        mul_b = sh_reg;
                    end
                    MS_VW: begin
                        mul_a = speed_reg;
                        mul_b = signed'({1'b0, inv_wb_reg});
                    end
                    MS_VWT: begin
                        mul_a = mul_res;
                        mul_b = tn_reg;
                    end
                    MS_DSTEER: begin
                        mul_a = signed'({1'b0, slg_reg});
                        mul_b = steer_err;
                    end
                    MS_DACCEL: begin
                        mul_a = signed'({1'b0, alg_reg});
                        mul_b = accel_err;
                    end
                    default: begin
                        // Sideslip factor 1 / (1 + v^2 / Vch^2).
                        mul_en     = 1'b0;
                        div_start  = 1'b1;
                        div_num    = bmes_pkg::ONE_Q;
                        div_den    = den_reg;
                        state_next = ST_DIV_G;
                    end
                endcase
            end
            ST_DIV_G: begin
                if (div_done) begin
                    state_next = ST_MUL_H;
                end
            end
            ST_MUL_H: begin
                mul_en     = 1'b1;
                mul_a      = t2_reg;
                mul_b      = gss_reg;
                state_next = ST_HSUM;
            end
            ST_HSUM: begin
                // Heading plus its increment, wrapped by the angle unit.
                ang_req.start = 1'b1;
                ang_in        = 34'(heading_reg) + 34'(mul_res >>> DT_SHIFT);
                state_next    = ST_WRAP_H;
            end
            ST_WRAP_H: begin
                if (ang_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mcnt_reg    <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mcnt_reg  <= mcnt_next;
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_wb_reg <= 31'd21845;
            inv_cs_reg <= 31'd164;
            slg_reg    <= 31'd655360;
            alg_reg    <= 31'd218453;
            srl_reg    <= 31'd32768;
            sal_reg    <= 31'd32768;
            all_reg    <= -32'sd262144;
            aul_reg    <= 31'd131072;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bmes_pkg::REG_INV_WHEELBASE:   inv_wb_reg <= cfg_wr_data[30:0];
                bmes_pkg::REG_INV_CHAR_SPD_SQ: inv_cs_reg <= cfg_wr_data[30:0];
                bmes_pkg::REG_STEER_LAG_GAIN:  slg_reg    <= cfg_wr_data[30:0];
                bmes_pkg::REG_ACCEL_LAG_GAIN:  alg_reg    <= cfg_wr_data[30:0];
                bmes_pkg::REG_STEER_RATE_LIM:  srl_reg    <= cfg_wr_data[30:0];
                bmes_pkg::REG_STEER_ANGLE_LIM: sal_reg    <= cfg_wr_data[30:0];
                bmes_pkg::REG_ACCEL_LOWER_LIM: all_reg    <= signed'(cfg_wr_data);
                bmes_pkg::REG_ACCEL_UPPER_LIM: aul_reg    <= cfg_wr_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Vehicle state: load writes, and the Euler update once the heading is wrapped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= 32'sd0;
            pos_y_reg   <= 32'sd0;
            heading_reg <= 32'sd0;
            steer_reg   <= 32'sd0;
            speed_reg   <= 32'sd0;
            accel_reg   <= 32'sd0;
            time_reg    <= 32'sd0;
        end else if (s_fire && s_mode) begin
            unique case (s_load_index)
                bmes_pkg::LD_POS_X:   pos_x_reg   <= s_load_value;
                bmes_pkg::LD_POS_Y:   pos_y_reg   <= s_load_value;
                bmes_pkg::LD_HEADING: heading_reg <= s_load_value;
                bmes_pkg::LD_STEER:   steer_reg   <= s_load_value;
                bmes_pkg::LD_SPEED:   speed_reg   <= s_load_value;
                bmes_pkg::LD_ACCEL:   accel_reg   <= s_load_value;
                bmes_pkg::LD_TIME:    time_reg    <= s_load_value;
                bmes_pkg::LD_NONE: begin
                end
                default: begin
                end
            endcase
        end else if ((state_reg == ST_WRAP_H) && ang_done) begin
            pos_x_reg   <= bmes_pkg::sat32(34'(pos_x_reg) + 34'(dx_reg >>> DT_SHIFT));
            pos_y_reg   <= bmes_pkg::sat32(34'(pos_y_reg) + 34'(dy_reg >>> DT_SHIFT));
            heading_reg <= ang_wrapped;
            steer_reg   <= steer_new;
            speed_reg   <= bmes_pkg::sat32(34'(speed_reg) + 34'(accel_reg >>> DT_SHIFT));
            accel_reg   <= accel_new;
            time_reg    <= bmes_pkg::sat32(34'(time_reg)
                                           + 34'(bmes_pkg::ONE_Q >>> DT_SHIFT));
        end
    end

    // Working registers of one step.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            dc_reg <= s_steer_command;
            ac_reg <= s_accel_command;
        end
        if ((state_reg == ST_ANG_H) && ang_done) begin
            ch_reg <= ang_cos;
            sh_reg <= ang_sin;
        end
        if ((state_reg == ST_DIV_T) && div_done) begin
            tn_reg <= div_q;
        end
        if ((state_reg == ST_DIV_G) && div_done) begin
            gss_reg <= div_q;
        end
        if (state_reg == ST_MUL) begin
            unique case (mcnt_reg)
                MS_DX:     den_reg <= bmes_pkg::sat32(34'(bmes_pkg::ONE_Q) + 34'(mul_res));
                MS_DY:     dx_reg  <= mul_res;
                MS_VW:     dy_reg  <= mul_res;
                MS_DSTEER: t2_reg  <= mul_res;
                MS_DACCEL: ds_reg  <= ds_clamped;
                MS_LAST:   da_reg  <= mul_res;
                default: begin
                end
            endcase
        end
    end

    // Output register takes a snapshot of the state.
    always_ff @(posedge aclk) begin
        if (m_load) begin
            o_x_reg <= pos_x_reg;
            o_y_reg <= pos_y_reg;
            o_h_reg <= heading_reg;
            o_s_reg <= steer_reg;
            o_v_reg <= speed_reg;
            o_a_reg <= accel_reg;
            o_t_reg <= time_reg;
        end
    end

endmodule
`default_nettype wire
